// ===== hw/rtl/srat_pkg.sv =====
// Shared types, constants and the gamma table function of the sample resolve tone map unit.
`default_nettype none
package srat_pkg;
  localparam int SampleW = 24;
  localparam int PixW = 16;
  localparam int CfgW = 11;
  localparam int PaddrW = 3;
  localparam int MaxSamplesDef = 1024;
  localparam int SampleFracBitsDef = 16;
  localparam int GammaDepthDef = 256;
  localparam int QueueDepth = 2;
  localparam int XW = 20;
  localparam int PolyW = 38;
  localparam int NumW = 42;
  localparam int DvdW = 60;
  localparam int DvsW = 44;
  localparam logic [17:0] AcesA = 18'd164495;
  localparam logic [17:0] AcesB = 18'd1966;
  localparam logic [17:0] AcesC = 18'd159252;
  localparam logic [17:0] AcesD = 18'd38666;
  localparam logic [17:0] AcesE = 18'd9175;
  localparam logic [XW-1:0] XMax = XW'(8 << 16);

  typedef struct packed {
    logic [SampleW-1:0] sample_red;
    logic [SampleW-1:0] sample_green;
    logic [SampleW-1:0] sample_blue;
  } sample_t;

  typedef struct packed {
    logic [PixW-1:0] pixel_red;
    logic [PixW-1:0] pixel_green;
    logic [PixW-1:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  typedef enum logic [3:0] {
    BkIdle, BkMeanStart, BkMeanWait, BkPoly1, BkPoly2, BkTStart, BkTWait,
    BkGam1, BkGam2, BkGam3, BkOut
  } bk_state_e;

  function automatic logic [15:0] gamma_val(input int unsigned i, input int unsigned d1);
    logic [255:0] rhs;
    logic [255:0] lhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    rhs = 256'd1;
    for (int k = 0; k < 5; k++) rhs = rhs * 256'(i);
    for (int k = 0; k < 11; k++) rhs = rhs * 256'(131070);
    lo = 0;
    hi = 65535;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 256'd1;
      for (int k = 0; k < 11; k++) lhs = lhs * 256'(2 * mid - 1);
      for (int k = 0; k < 5; k++) lhs = lhs * 256'(d1);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return 16'(lo);
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/srat_front.sv =====
// Front end: clamps samples, accumulates channel sums and queues finished pixels.
`default_nettype none
module srat_front #(
  parameter int MaxSamples = srat_pkg::MaxSamplesDef,
  parameter int SampleFracBits = srat_pkg::SampleFracBitsDef,
  parameter int SumW = 30,
  parameter int NW = 11
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire srat_pkg::sample_t          sample_i,
  input  wire logic                       sample_valid_i,
  output logic                            sample_ready_o,
  input  wire logic [srat_pkg::CfgW-1:0]  spp_i,
  input  wire srat_pkg::fifo_st_t         fifo_st_i,
  output logic                            push_o,
  output logic [3*SumW+NW-1:0]            job_o
);
  localparam int CntW = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int LimW = (SampleFracBits + 4 > srat_pkg::SampleW) ?
                        SampleFracBits + 4 : srat_pkg::SampleW;
  localparam logic [LimW-1:0] Lim = LimW'(8) << SampleFracBits;

  logic [SumW-1:0] r_q, g_q, b_q, r_d, g_d, b_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   n;
  logic [LimW-1:0] er, eg, eb, cr, cg, cb;
  logic            accept, last;

  assign sample_ready_o = !fifo_st_i.full;
  assign accept = sample_valid_i && sample_ready_o;

  always_comb begin
    if (spp_i == '0) n = NW'(1);
    else if (32'(spp_i) > 32'(MaxSamples)) n = NW'(MaxSamples);
    else n = NW'(spp_i);
    er = LimW'(sample_i.sample_red);
    eg = LimW'(sample_i.sample_green);
    eb = LimW'(sample_i.sample_blue);
    cr = (er > Lim) ? Lim : er;
    cg = (eg > Lim) ? Lim : eg;
    cb = (eb > Lim) ? Lim : eb;
    last = !(32'(cnt_q) + 32'd1 < 32'(n));
    r_d = r_q + SumW'(cr);
    g_d = g_q + SumW'(cg);
    b_d = b_q + SumW'(cb);
    cnt_d = cnt_q + CntW'(1);
  end

  assign push_o = accept && last;
  assign job_o = {r_d, g_d, b_d, n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
      g_q <= '0;
      b_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      if (last) begin
        r_q <= '0;
        g_q <= '0;
        b_q <= '0;
        cnt_q <= '0;
      end else begin
        r_q <= r_d;
        g_q <= g_d;
        b_q <= b_d;
        cnt_q <= cnt_d;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/srat_fifo.sv =====
// Short queue of finished pixel sums between front and back.
`default_nettype none
module srat_fifo #(
  parameter int Width = 8,
  parameter int Depth = srat_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [Width-1:0]  data_i,
  input  wire logic              pop_i,
  output logic [Width-1:0]       data_o,
  output srat_pkg::fifo_st_t     st_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [PtrW:0]    cnt_q;

  assign st_o.full = (32'(cnt_q) == 32'(Depth));
  assign st_o.empty = (cnt_q == '0);
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (32'(wp_q) == Depth - 1) ? '0 : wp_q + PtrW'(1);
      if (pop_i) rp_q <= (32'(rp_q) == Depth - 1) ? '0 : rp_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (PtrW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (PtrW+1)'(1);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/srat_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module srat_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [srat_pkg::DvdW-1:0]  dividend_i,
  input  wire logic [srat_pkg::DvsW-1:0]  divisor_i,
  output logic                            done_o,
  output logic [srat_pkg::DvdW-1:0]       quot_o
);
  localparam int Dvd = srat_pkg::DvdW;
  localparam int Dvs = srat_pkg::DvsW;
  localparam int CntW = $clog2(Dvd + 1);

  logic [Dvd-1:0]  q_q;
  logic [Dvs-1:0]  r_q, d_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [Dvs:0]    rs, rn;
  logic            ge;

  always_comb begin
    rs = {r_q, q_q[Dvd-1]};
    ge = rs >= {1'b0, d_q};
    rn = ge ? rs - {1'b0, d_q} : rs;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      d_q <= divisor_i;
      r_q <= '0;
    end else if (busy_q) begin
      q_q <= {q_q[Dvd-2:0], ge};
      r_q <= rn[Dvs-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CntW'(Dvd);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/srat_back.sv =====
// Back end: mean, filmic curve, gamma lookup and the output register, one channel at a time.
`default_nettype none
module srat_back #(
  parameter int SampleFracBits = srat_pkg::SampleFracBitsDef,
  parameter int GammaDepth = srat_pkg::GammaDepthDef,
  parameter int SumW = 30,
  parameter int NW = 11
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [3*SumW+NW-1:0]  job_i,
  input  wire srat_pkg::fifo_st_t    fifo_st_i,
  output logic                       pop_o,
  output srat_pkg::pixel_t           pixel_o,
  output logic                       pixel_valid_o,
  input  wire logic                  pixel_ready_i
);
  localparam int IW = $clog2(GammaDepth);
  localparam int PW = 17 + IW;
  localparam int Sh1 = (SampleFracBits > 16) ? SampleFracBits - 17 : 0;
  localparam int Sh2 = (SampleFracBits > 16) ? SampleFracBits - 16 : 0;
  localparam int Sh3 = (SampleFracBits < 16) ? 16 - SampleFracBits : 0;
  localparam int XW = srat_pkg::XW;
  localparam int PolyW = srat_pkg::PolyW;
  localparam int NumW = srat_pkg::NumW;
  localparam int Dvd = srat_pkg::DvdW;
  localparam int Dvs = srat_pkg::DvsW;

  logic [15:0] gtab [GammaDepth];
  for (genvar g = 0; g < GammaDepth; g++) begin : g_tab
    assign gtab[g] = srat_pkg::gamma_val(g, GammaDepth - 1);
  end

  srat_pkg::bk_state_e state_q, state_d;
  logic [3*SumW+NW-1:0] job_q;
  logic [1:0]        ch_q, ch_d;
  logic [XW-1:0]     x_q;
  logic [PolyW-1:0]  pa_q, pc_q;
  logic [NumW-1:0]   num_q, den_q;
  logic [16:0]       t_q;
  logic [IW:0]       idx_q;
  logic [15:0]       frac_q, lo_q, res_q [3];
  logic [31:0]       prod_q;
  logic              out_valid_q;
  srat_pkg::pixel_t  pixel_q;

  logic            div_start, div_done;
  logic [Dvd-1:0]  div_dvd, div_quot;
  logic [Dvs-1:0]  div_dvs;
  logic [SumW-1:0] sum;
  logic [NW-1:0]   n;
  logic [63:0]     x64;
  logic [57:0]     ma, mc;
  logic [PW-1:0]   p;
  logic [15:0]     hi, lo;
  logic            load_out;

  srat_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dvd), .divisor_i(div_dvs),
    .done_o(div_done), .quot_o(div_quot)
  );

  always_comb begin
    n = job_q[NW-1:0];
    case (ch_q)
      2'd0: sum = job_q[3*SumW+NW-1 -: SumW];
      2'd1: sum = job_q[2*SumW+NW-1 -: SumW];
      default: sum = job_q[SumW+NW-1 -: SumW];
    endcase
    if (SampleFracBits > 16) x64 = (64'(div_quot) + (64'd1 << Sh1)) >> Sh2;
    else x64 = 64'(div_quot) << Sh3;
    ma = 58'(pa_q) * 58'(x_q);
    mc = 58'(pc_q) * 58'(x_q);
    p = PW'(t_q) * PW'(GammaDepth - 1);
    lo = gtab[idx_q[IW-1:0]];
    hi = gtab[idx_q[IW-1:0] + IW'(1)];
  end

  always_comb begin
    state_d = state_q;
    ch_d = ch_q;
    pop_o = 1'b0;
    div_start = 1'b0;
    div_dvd = Dvd'(sum) + Dvd'(n >> 1);
    div_dvs = Dvs'(n);
    load_out = 1'b0;
    case (state_q)
      srat_pkg::BkIdle: begin
        if (!fifo_st_i.empty) begin
          pop_o = 1'b1;
          ch_d = 2'd0;
          state_d = srat_pkg::BkMeanStart;
        end
      end
      srat_pkg::BkMeanStart: begin
        div_start = 1'b1;
        state_d = srat_pkg::BkMeanWait;
      end
      srat_pkg::BkMeanWait: if (div_done) state_d = srat_pkg::BkPoly1;
      srat_pkg::BkPoly1: state_d = srat_pkg::BkPoly2;
      srat_pkg::BkPoly2: state_d = srat_pkg::BkTStart;
      srat_pkg::BkTStart: begin
        div_start = 1'b1;
        div_dvd = Dvd'({num_q, 16'd0}) + Dvd'(den_q >> 1);
        div_dvs = Dvs'(den_q);
        state_d = srat_pkg::BkTWait;
      end
      srat_pkg::BkTWait: if (div_done) state_d = srat_pkg::BkGam1;
      srat_pkg::BkGam1: state_d = srat_pkg::BkGam2;
      srat_pkg::BkGam2: state_d = srat_pkg::BkGam3;
      srat_pkg::BkGam3: begin
        if (ch_q == 2'd2) state_d = srat_pkg::BkOut;
        else begin
          ch_d = ch_q + 2'd1;
          state_d = srat_pkg::BkMeanStart;
        end
      end
      srat_pkg::BkOut: begin
        if (!out_valid_q || pixel_ready_i) begin
          load_out = 1'b1;
          state_d = srat_pkg::BkIdle;
        end
      end
      default: state_d = srat_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (state_q == srat_pkg::BkMeanWait && div_done)
      x_q <= (x64 > 64'(srat_pkg::XMax)) ? srat_pkg::XMax : XW'(x64);
    if (state_q == srat_pkg::BkPoly1) begin
      pa_q <= PolyW'(srat_pkg::AcesA) * PolyW'(x_q) + (PolyW'(srat_pkg::AcesB) << 16);
      pc_q <= PolyW'(srat_pkg::AcesC) * PolyW'(x_q) + (PolyW'(srat_pkg::AcesD) << 16);
    end
    if (state_q == srat_pkg::BkPoly2) begin
      num_q <= ma[57:16];
      den_q <= mc[57:16] + (NumW'(srat_pkg::AcesE) << 16);
    end
    if (state_q == srat_pkg::BkTWait && div_done)
      t_q <= (div_quot > Dvd'(65536)) ? 17'd65536 : div_quot[16:0];
    if (state_q == srat_pkg::BkGam1) begin
      idx_q <= p[PW-1:16];
      frac_q <= p[15:0];
    end
    if (state_q == srat_pkg::BkGam2) begin
      if (32'(idx_q) >= GammaDepth - 1) begin
        lo_q <= gtab[GammaDepth-1];
        prod_q <= '0;
      end else begin
        lo_q <= lo;
        prod_q <= 32'((hi < lo) ? 16'd0 : hi - lo) * 32'(frac_q);
      end
    end
    if (state_q == srat_pkg::BkGam3) res_q[ch_q] <= lo_q + 16'((33'(prod_q) + 33'd32768) >> 16);
    if (load_out) begin
      pixel_q.pixel_red <= res_q[0];
      pixel_q.pixel_green <= res_q[1];
      pixel_q.pixel_blue <= res_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srat_pkg::BkIdle;
      ch_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q <= ch_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (pixel_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign pixel_o = pixel_q;
  assign pixel_valid_o = out_valid_q;
endmodule
`default_nettype wire

// ===== hw/rtl/sample_resolve_aces_tonemap_unit.sv =====
// Top level of the sample resolve and filmic tone map unit.
//
// Samples enter on sample_i with a valid/ready transfer; three channels in
// unsigned fixed point. The front accepts one sample per cycle while the
// queue is not full, clamps each channel at 8.0 and adds it into the channel
// sums. The sample that completes a pixel (samples_per_pixel, APB register at
// address 0) moves the sums into a two-entry queue; sample_ready_o drops only
// while that queue is full. The back takes one pixel at a time and works the
// channels in turn through one shared radix-2 divider: per channel one mean
// division and one curve division, plus the multiply and gamma lookup steps.
// The result waits in pixel_o until pixel_ready_i; the back keeps working the
// next pixel meanwhile and holds only when a new result is ready and the
// output is still not taken. Reset clears the sums, the count, the queue and
// the output valid, and sets samples_per_pixel to 1. The gamma table is
// constant.
`default_nettype none
module sample_resolve_aces_tonemap_unit #(
  parameter int MaxSamples = srat_pkg::MaxSamplesDef,
  parameter int SampleFracBits = srat_pkg::SampleFracBitsDef,
  parameter int GammaDepth = srat_pkg::GammaDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire srat_pkg::sample_t            sample_i,
  input  wire logic                         sample_valid_i,
  output logic                              sample_ready_o,
  output srat_pkg::pixel_t                  pixel_o,
  output logic                              pixel_valid_o,
  input  wire logic                         pixel_ready_i,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [srat_pkg::PaddrW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  localparam int NW = $clog2(MaxSamples + 1);
  localparam int SumW = $clog2(MaxSamples) + 3 + SampleFracBits + 1;
  localparam int JobW = 3 * SumW + NW;

  logic [srat_pkg::CfgW-1:0] spp_q;
  logic                      push, pop;
  logic [JobW-1:0]           job_in, job_out;
  srat_pkg::fifo_st_t        fifo_st;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(spp_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) spp_q <= srat_pkg::CfgW'(1);
    else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
      spp_q <= pwdata[srat_pkg::CfgW-1:0];
  end

  srat_front #(
    .MaxSamples(MaxSamples), .SampleFracBits(SampleFracBits), .SumW(SumW), .NW(NW)
  ) u_front (
    .clk_i, .rst_ni, .sample_i, .sample_valid_i, .sample_ready_o,
    .spp_i(spp_q), .fifo_st_i(fifo_st), .push_o(push), .job_o(job_in)
  );

  srat_fifo #(.Width(JobW), .Depth(srat_pkg::QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(job_in), .pop_i(pop),
    .data_o(job_out), .st_o(fifo_st)
  );

  srat_back #(
    .SampleFracBits(SampleFracBits), .GammaDepth(GammaDepth), .SumW(SumW), .NW(NW)
  ) u_back (
    .clk_i, .rst_ni, .job_i(job_out), .fifo_st_i(fifo_st), .pop_o(pop),
    .pixel_o, .pixel_valid_o, .pixel_ready_i
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_st.full) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_st.empty) else $error("queue read while empty");
  a_ready_tracks_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_ready_o == !fifo_st.full) else $error("sample ready out of step with queue");
endmodule
`default_nettype wire

// ===== tb/sample_resolve_aces_tonemap_unit_tb.sv =====
// Testbench of the sample resolve and filmic tone map unit with a pixel scoreboard.
`default_nettype none
module sample_resolve_aces_tonemap_unit_tb;
  localparam int Depth = srat_pkg::GammaDepthDef;
  localparam int SW = srat_pkg::SampleW;
  localparam int AW = srat_pkg::PaddrW;
  localparam logic [AW-1:0] AddrSpp = AW'(0);
  localparam logic [AW-1:0] AddrUnmapped = AW'(4);

  class pixel_board;
    logic [15:0] gamma_lut [Depth];
    longint unsigned sum_r, sum_g, sum_b;
    int unsigned taken;
    int unsigned spp;
    srat_pkg::pixel_t expected_q[$];
    int unsigned errors;
    int unsigned pixels_seen;

    function new();
      logic [255:0] rhs, lhs;
      int unsigned lo, hi, mid;
      for (int i = 0; i < Depth; i++) begin
        rhs = 256'd1;
        for (int k = 0; k < 5; k++) rhs = rhs * 256'(i);
        for (int k = 0; k < 11; k++) rhs = rhs * 256'(131070);
        lo = 0;
        hi = 65535;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          lhs = 256'd1;
          for (int k = 0; k < 11; k++) lhs = lhs * 256'(2 * mid - 1);
          for (int k = 0; k < 5; k++) lhs = lhs * 256'(Depth - 1);
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        gamma_lut[i] = 16'(lo);
      end
      sum_r = 0; sum_g = 0; sum_b = 0;
      taken = 0;
      spp = 1;
      errors = 0;
      pixels_seen = 0;
    endfunction

    function void write_reg(logic [AW-1:0] addr, logic [31:0] data);
      if (addr == AddrSpp) spp = data & 32'h7ff;
    endfunction

    function longint unsigned clip8(logic [SW-1:0] v);
      longint unsigned lim;
      lim = 64'd8 << srat_pkg::SampleFracBitsDef;
      return (v > lim) ? lim : longint'(v);
    endfunction

    function logic [15:0] tonemap(longint unsigned total, int unsigned n);
      longint unsigned x, num, den, t, p, idx, frac, lo, hi;
      x = (total + n / 2) / n;
      if (x > (64'd8 << 16)) x = 64'd8 << 16;
      num = ((64'(srat_pkg::AcesA) * x + (64'(srat_pkg::AcesB) << 16)) * x) >> 16;
      den = (((64'(srat_pkg::AcesC) * x + (64'(srat_pkg::AcesD) << 16)) * x) >> 16)
            + (64'(srat_pkg::AcesE) << 16);
      t = ((num << 16) + den / 2) / den;
      if (t > 65536) t = 65536;
      p = t * (Depth - 1);
      idx = p >> 16;
      frac = p & 64'hffff;
      if (idx >= Depth - 1) return gamma_lut[Depth-1];
      lo = gamma_lut[idx];
      hi = gamma_lut[idx+1];
      if (hi < lo) hi = lo;
      return 16'(lo + (((hi - lo) * frac + 32768) >> 16));
    endfunction

    function void note_sample(srat_pkg::sample_t s);
      int unsigned n;
      srat_pkg::pixel_t px;
      n = (spp == 0) ? 1 : (spp > srat_pkg::MaxSamplesDef) ? srat_pkg::MaxSamplesDef : spp;
      sum_r += clip8(s.sample_red);
      sum_g += clip8(s.sample_green);
      sum_b += clip8(s.sample_blue);
      if (taken + 1 < n) begin
        taken++;
      end else begin
        px.pixel_red = tonemap(sum_r, n);
        px.pixel_green = tonemap(sum_g, n);
        px.pixel_blue = tonemap(sum_b, n);
        expected_q.push_back(px);
        sum_r = 0; sum_g = 0; sum_b = 0;
        taken = 0;
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check(srat_pkg::pixel_t px);
      srat_pkg::pixel_t e;
      pixels_seen++;
      if (expected_q.size() == 0) begin
        report("unexpected pixel", 32'(px.pixel_red), 0);
      end else begin
        e = expected_q.pop_front();
        if (px.pixel_red !== e.pixel_red) report("pixel_red", px.pixel_red, e.pixel_red);
        if (px.pixel_green !== e.pixel_green)
          report("pixel_green", px.pixel_green, e.pixel_green);
        if (px.pixel_blue !== e.pixel_blue) report("pixel_blue", px.pixel_blue, e.pixel_blue);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  srat_pkg::sample_t sample_i = '0;
  logic sample_valid_i = 1'b0;
  logic sample_ready_o;
  srat_pkg::pixel_t pixel_o;
  logic pixel_valid_o;
  logic pixel_ready_i = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pixel_board board = new();
  int unsigned tx_idle_pct = 17;
  int unsigned rx_idle_pct = 70;
  int unsigned sent = 0;

  sample_resolve_aces_tonemap_unit uut (
    .clk_i, .rst_ni, .sample_i, .sample_valid_i, .sample_ready_o,
    .pixel_o, .pixel_valid_o, .pixel_ready_i,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    pixel_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(negedge clk_i) begin
    if (rst_ni && pixel_valid_o && pixel_ready_i) board.check(pixel_o);
  end

  task reg_write(logic [AW-1:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    board.write_reg(addr, data);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task update_idling();
    if (sent > 833) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end else if (sent > 416) begin
      tx_idle_pct = 70;
      rx_idle_pct = 17;
    end
  endtask

  task put_sample(srat_pkg::sample_t s);
    update_idling();
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sample_valid_i <= 1'b1;
    sample_i <= s;
    @(negedge clk_i);
    while (!sample_ready_o) @(negedge clk_i);
    board.note_sample(s);
    sent++;
    @(posedge clk_i);
  endtask

  task drain();
    sample_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function logic [SW-1:0] rand_channel();
    case ($urandom_range(3))
      0: return SW'($urandom);
      1: return SW'($urandom_range(0, 24'h80000));
      2: return SW'($urandom_range(0, 24'h4000));
      default: begin
        case ($urandom_range(3))
          0: return 24'h080000;
          1: return 24'hffffff;
          2: return 24'h000000;
          default: return 24'h07ffff;
        endcase
      end
    endcase
  endfunction

  function srat_pkg::sample_t rand_sample();
    srat_pkg::sample_t s;
    s.sample_red = rand_channel();
    s.sample_green = rand_channel();
    s.sample_blue = rand_channel();
    return s;
  endfunction

  initial begin
    logic [SW-1:0] counts [8];
    int unsigned n;
    counts = '{24'h000000, 24'hffffff, 24'h080000, 24'h080001,
               24'h07ffff, 24'h000001, 24'h010000, 24'h555555};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < 8; i++)
      put_sample('{counts[i], counts[(i + 3) % 8], counts[(i + 5) % 8]});
    put_sample('{24'haaaaaa, 24'h000000, 24'hfffffe});
    put_sample(rand_sample());
    drain();
    reg_write(AddrUnmapped, 32'd7);
    put_sample(rand_sample());
    put_sample(rand_sample());
    drain();
    reg_write(AddrSpp, 32'd0);
    put_sample(rand_sample());
    put_sample(rand_sample());
    drain();
    reg_write(AddrSpp, 32'd8);
    for (int i = 0; i < 5; i++) put_sample('{24'hffffff, 24'h020000, 24'h000100});
    drain();
    reg_write(AddrSpp, 32'd3);
    put_sample('{24'hffffff, 24'hffffff, 24'hffffff});
    drain();

    reg_write(AddrSpp, 32'd2047);
    for (int i = 0; i < 1024; i++) put_sample(rand_sample());
    drain();
    while (sent < 1250) begin
      case ($urandom_range(9))
        0, 1, 2, 3: n = 1;
        4, 5, 6: n = $urandom_range(2, 4);
        7, 8: n = $urandom_range(5, 16);
        default: n = $urandom_range(17, 64);
      endcase
      reg_write(AddrSpp, n);
      for (int i = $urandom_range(20, 80); i > 0; i--) put_sample(rand_sample());
      drain();
    end

    repeat (500) @(posedge clk_i);
    $display("%0d samples sent, %0d pixels checked, sample counts from 0 to 2047",
             sent, board.pixels_seen);
    if (board.errors == 0) begin
      $display("sample_resolve_aces_tonemap_unit_tb OK");
    end else begin
      $display("sample_resolve_aces_tonemap_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout");
    $display("sample_resolve_aces_tonemap_unit_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
